// File: src/rtc_pkg.sv
package rtc_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [10:0] MS_PER_SEC   = 11'd1000;
  localparam logic [6:0]  SEC_PER_MIN  = 7'd60;
  localparam logic [6:0]  MIN_PER_HOUR = 7'd60;
  localparam logic [5:0]  HOUR_PER_DAY = 6'd24;
  localparam logic [4:0]  MONTHS       = 5'd12;
  localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [7:0]  TICKS_RESET  = 8'd6;

  typedef struct packed {
    logic [9:0] ms;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
  } cal_t;

  // Gregorian rule folded onto an 8-bit year: 0 is a leap year, 100 and 200 are not
  function automatic logic is_leap(input logic [7:0] year);
    is_leap = (year[1:0] == 2'b00) && (year != 8'd100) && (year != 8'd200);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic [7:0] year);
    case (month)
      4'd2:    month_len = 5'd28;
      4'd4:    month_len = 5'd30;
      4'd6:    month_len = 5'd30;
      4'd9:    month_len = 5'd30;
      4'd11:   month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
    if ((month == MONTH_FEB) && is_leap(year)) begin
      month_len = FEB_LEAP_LEN;
    end
  endfunction

endpackage

// File: src/rtc_advance.sv
module rtc_advance (
  input  rtc_pkg::cal_t cal_i,
  output rtc_pkg::cal_t cal_o
);
  import rtc_pkg::*;

  logic [10:0] ms_inc;
  logic [6:0]  sec_inc;
  logic [6:0]  min_inc;
  logic [5:0]  hour_inc;
  logic [5:0]  day_inc;
  logic [4:0]  month_inc;
  logic [4:0]  day_limit;

  assign ms_inc    = {1'b0, cal_i.ms} + 11'd1;
  assign sec_inc   = {1'b0, cal_i.sec} + 7'd1;
  assign min_inc   = {1'b0, cal_i.min} + 7'd1;
  assign hour_inc  = {1'b0, cal_i.hour} + 6'd1;
  assign day_inc   = {1'b0, cal_i.day} + 6'd1;
  assign month_inc = {1'b0, cal_i.month} + 5'd1;
  assign day_limit = month_len(cal_i.month, cal_i.year);

  // ripple the carry upward; each field only moves when everything below wrapped
  always_comb begin
    cal_o = cal_i;
    cal_o.ms = ms_inc[9:0];
    if (ms_inc >= MS_PER_SEC) begin
      cal_o.ms  = '0;
      cal_o.sec = sec_inc[5:0];
      if (sec_inc >= SEC_PER_MIN) begin
        cal_o.sec = '0;
        cal_o.min = min_inc[5:0];
        if (min_inc >= MIN_PER_HOUR) begin
          cal_o.min  = '0;
          cal_o.hour = hour_inc[4:0];
          if (hour_inc >= HOUR_PER_DAY) begin
            cal_o.hour = '0;
            cal_o.day  = day_inc[4:0];
            if (day_inc > {1'b0, day_limit}) begin
              cal_o.day   = 5'd1;
              cal_o.month = month_inc[3:0];
              if (month_inc > MONTHS) begin
                cal_o.month = 4'd1;
                cal_o.year  = cal_i.year + 8'd1;
              end
            end
          end
        end
      end
    end
  end

endmodule

// File: src/rtc_calendar_counter.sv
// Each accepted input beat is registered and yields its result beat in the following cycle.
// Throughput: one item per cycle while out_ready_i is high; the carry chain
// through all calendar fields is a single combinational pass between the state registers.
// Reset: asynchronous, active low; calendar returns to day 1, month 1, year 0,
// counters and prescaler clear, the prescaler limit returns to 6.
module rtc_calendar_counter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [9:0] set_ms_i,
  input  logic [5:0] set_sec_i,
  input  logic [5:0] set_min_i,
  input  logic [4:0] set_hour_i,
  input  logic [4:0] set_day_i,
  input  logic [3:0] set_month_i,
  input  logic [7:0] set_year_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [9:0] time_ms_o,
  output logic [5:0] time_sec_o,
  output logic [5:0] time_min_o,
  output logic [4:0] time_hour_o,
  output logic [4:0] time_day_o,
  output logic [3:0] time_month_o,
  output logic [7:0] time_year_o,
  output logic [15:0] running_ms_o
);
  import rtc_pkg::*;

  cal_t        cal_q, cal_d, cal_adv;
  logic [7:0]  sub_tick_q, sub_tick_d;
  logic [15:0] free_ms_q, free_ms_d;
  logic [7:0]  ticks_q;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  sub_inc;
  logic        ms_done;
  logic        in_fire;

  rtc_advance u_advance (
    .cal_i (cal_q),
    .cal_o (cal_adv)
  );

  // the state registers double as the result register
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign sub_inc = sub_tick_q + 8'd1;
  assign ms_done = (sub_inc >= ticks_q);

  always_comb begin
    cal_d       = cal_q;
    sub_tick_d  = sub_tick_q;
    free_ms_d   = free_ms_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_fire) begin
      out_valid_d = 1'b1;
      if (opcode_i == OP_LOAD) begin
        cal_d.ms    = set_ms_i;
        cal_d.sec   = set_sec_i;
        cal_d.min   = set_min_i;
        cal_d.hour  = set_hour_i;
        cal_d.day   = set_day_i;
        cal_d.month = set_month_i;
        cal_d.year  = set_year_i;
      end else if (ms_done) begin
        sub_tick_d = '0;
        free_ms_d  = free_ms_q + 16'd1;
        cal_d      = cal_adv;
      end else begin
        sub_tick_d = sub_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q       <= '{ms: '0, sec: '0, min: '0, hour: '0, day: 5'd1, month: 4'd1, year: '0};
      sub_tick_q  <= '0;
      free_ms_q   <= '0;
      ticks_q     <= TICKS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cal_q       <= cal_d;
      sub_tick_q  <= sub_tick_d;
      free_ms_q   <= free_ms_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        ticks_q <= cfg_data_i;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign time_ms_o    = cal_q.ms;
  assign time_sec_o   = cal_q.sec;
  assign time_min_o   = cal_q.min;
  assign time_hour_o  = cal_q.hour;
  assign time_day_o   = cal_q.day;
  assign time_month_o = cal_q.month;
  assign time_year_o  = cal_q.year;
  assign running_ms_o = free_ms_q;

`ifndef NO_ASSERTIONS
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted beat produced no result");

  a_load_keeps_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (opcode_i == OP_LOAD)) |=> ($stable(free_ms_q) && $stable(sub_tick_q)))
    else $error("load disturbed prescaler or running count");

  a_ms_step_clears_prescaler: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (opcode_i == OP_TICK)) ##1 (free_ms_q != $past(free_ms_q))
      |-> (sub_tick_q == 8'd0))
    else $error("millisecond advanced without clearing prescaler");
`endif

endmodule

// File: sim/rtc_calendar_counter_tb.sv
module rtc_calendar_counter_tb;
  import rtc_pkg::*;

  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    cal_t        cal;
    logic [15:0] running;
  } stamp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = OP_TICK;
  cal_t        set_cal = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  wire cal_t   time_cal;
  logic [15:0] running_ms;

  // Calendar predictor state
  cal_t        model_cal;
  logic [7:0]  model_sub;
  logic [15:0] model_run;
  logic [7:0]  model_ticks;
  stamp_t      stamp_q[$];

  int fail_cnt = 0;
  int sent_cnt = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int cur_ticks = TICKS_RESET;

  rtc_calendar_counter DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .opcode_i     (opcode),
    .set_ms_i     (set_cal.ms),
    .set_sec_i    (set_cal.sec),
    .set_min_i    (set_cal.min),
    .set_hour_i   (set_cal.hour),
    .set_day_i    (set_cal.day),
    .set_month_i  (set_cal.month),
    .set_year_i   (set_cal.year),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .time_ms_o    (time_cal.ms),
    .time_sec_o   (time_cal.sec),
    .time_min_o   (time_cal.min),
    .time_hour_o  (time_cal.hour),
    .time_day_o   (time_cal.day),
    .time_month_o (time_cal.month),
    .time_year_o  (time_cal.year),
    .running_ms_o (running_ms)
  );

  always #2 clk = ~clk;

  function automatic int month_days(input logic [3:0] mon, input logic [7:0] yr);
    int  yi;
    bit  leap;
    yi   = yr;
    leap = ((yi % 4 == 0) && (yi % 100 != 0)) || (yi % 400 == 0);
    case (mon)
      4'd2:                      month_days = leap ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_days = 30;
      default:                   month_days = 31;
    endcase
  endfunction

  // Advance the predicted calendar by one item and return the time it reports
  function automatic stamp_t step_calendar(input logic op, input cal_t load);
    int     t;
    bit     carry;
    stamp_t res;
    if (op == OP_LOAD) begin
      model_cal = load;
    end else begin
      model_sub = model_sub + 8'd1;
      if (model_sub >= model_ticks) begin
        model_sub = '0;
        model_run = model_run + 16'd1;
        t = model_cal.ms + 1;
        carry = (t >= 1000);
        model_cal.ms = carry ? 10'd0 : 10'(t);
        if (carry) begin
          t = model_cal.sec + 1;
          carry = (t >= 60);
          model_cal.sec = carry ? 6'd0 : 6'(t);
        end
        if (carry) begin
          t = model_cal.min + 1;
          carry = (t >= 60);
          model_cal.min = carry ? 6'd0 : 6'(t);
        end
        if (carry) begin
          t = model_cal.hour + 1;
          carry = (t >= 24);
          model_cal.hour = carry ? 5'd0 : 5'(t);
        end
        if (carry) begin
          t = model_cal.day + 1;
          carry = (t > month_days(model_cal.month, model_cal.year));
          model_cal.day = carry ? 5'd1 : 5'(t);
        end
        if (carry) begin
          t = model_cal.month + 1;
          carry = (t > 12);
          model_cal.month = carry ? 4'd1 : 4'(t);
        end
        if (carry) begin
          model_cal.year = model_cal.year + 8'd1;
        end
      end
    end
    res.cal     = model_cal;
    res.running = model_run;
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Predict on every input beat, compare on every result beat
  always @(posedge clk or negedge rst_n) begin : monitor
    stamp_t want;
    if (!rst_n) begin
      model_cal       = '0;
      model_cal.day   = 5'd1;
      model_cal.month = 4'd1;
      model_sub       = '0;
      model_run       = '0;
      model_ticks     = TICKS_RESET;
      stamp_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        model_ticks = cfg_data;
      end
      if (in_valid && in_ready) begin
        stamp_q.push_back(step_calendar(opcode, set_cal));
      end
      if (out_valid && out_ready) begin
        if (stamp_q.size() == 0) begin
          $error("result beat with no expected time waiting");
          fail_cnt++;
        end else begin
          want = stamp_q.pop_front();
          check_field("time_ms", want.cal.ms, time_cal.ms);
          check_field("time_sec", want.cal.sec, time_cal.sec);
          check_field("time_min", want.cal.min, time_cal.min);
          check_field("time_hour", want.cal.hour, time_cal.hour);
          check_field("time_day", want.cal.day, time_cal.day);
          check_field("time_month", want.cal.month, time_cal.month);
          check_field("time_year", want.cal.year, time_cal.year);
          check_field("running_ms", want.running, running_ms);
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold when one is requested
  always @(posedge clk) begin : receiver
    int hold_left;
    int hold_seen;
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic op, input cal_t v);
    int gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    set_cal  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
  endtask

  // Tick with junk in the load fields, which must be ignored
  task automatic send_tick();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    send_item(OP_TICK, raw[$bits(cal_t)-1:0]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (stamp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ticks(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_ticks = v;
  endtask

  // Valid calendar sitting close to a carry in most fields
  function automatic cal_t near_rollover();
    cal_t c;
    int   len;
    case ($urandom_range(0, 7))
      0: c.year = 8'd0;
      1: c.year = 8'd99;
      2: c.year = 8'd100;
      3: c.year = 8'd200;
      4: c.year = 8'd255;
      5: c.year = 8'd4;
      default: c.year = 8'($urandom_range(0, 255));
    endcase
    c.month = 4'($urandom_range(1, 12));
    len     = month_days(c.month, c.year);
    c.day   = ($urandom_range(3) != 0) ? 5'(len - $urandom_range(0, 1))
                                       : 5'($urandom_range(1, len));
    c.hour  = ($urandom_range(3) != 0) ? 5'd23 : 5'($urandom_range(0, 23));
    c.min   = ($urandom_range(3) != 0) ? 6'd59 : 6'($urandom_range(0, 59));
    c.sec   = ($urandom_range(3) != 0) ? 6'd59 : 6'($urandom_range(0, 59));
    c.ms    = ($urandom_range(3) != 0) ? 10'(999 - $urandom_range(0, 3))
                                       : 10'($urandom_range(0, 999));
    return c;
  endfunction

  task automatic random_sequence();
    int          r;
    int          k;
    logic [63:0] raw;
    r = $urandom_range(99);
    if (r < 70) begin
      send_item(OP_LOAD, near_rollover());
      if (cur_ticks > 16) begin
        k = $urandom_range(1, 300);
      end else begin
        k = $urandom_range(1, 5 * ((cur_ticks == 0) ? 1 : cur_ticks));
      end
      repeat (k) send_tick();
    end else if (r < 85) begin
      // raw load at full field widths, in range or not
      raw = {$urandom, $urandom};
      send_item(OP_LOAD, raw[$bits(cal_t)-1:0]);
      repeat ($urandom_range(1, 3)) send_tick();
    end else begin
      repeat ($urandom_range(1, 8)) send_tick();
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int n);
    int target;
    send_idle_pct = idle;
    stall_pct     = stall;
    target        = sent_cnt + n;
    while (sent_cnt < target) random_sequence();
    wait_idle();
  endtask

  task automatic test_reset_values();
    repeat (7) send_tick();
    wait_idle();
  endtask

  task automatic test_calendar_rollover();
    write_ticks(8'd1);
    // year wraps past 255
    send_item(OP_LOAD, {10'd999, 6'd59, 6'd59, 5'd23, 5'd31, 4'd12, 8'd255});
    send_tick();
    // leap February in year 0
    send_item(OP_LOAD, {10'd999, 6'd59, 6'd59, 5'd23, 5'd28, 4'd2, 8'd0});
    send_tick();
    send_item(OP_LOAD, {10'd999, 6'd59, 6'd59, 5'd23, 5'd29, 4'd2, 8'd0});
    send_tick();
    // century year is not a leap year
    send_item(OP_LOAD, {10'd999, 6'd59, 6'd59, 5'd23, 5'd28, 4'd2, 8'd100});
    send_tick();
    wait_idle();
  endtask

  task automatic test_out_of_range();
    send_item(OP_LOAD, '1);
    send_tick();
    send_item(OP_LOAD, '0);
    send_tick();
    wait_idle();
  endtask

  task automatic test_prescaler();
    write_ticks(8'd200);
    repeat (4) send_tick();
    wait_idle();
    // lower the limit below the prescaler count
    write_ticks(8'd3);
    send_tick();
    wait_idle();
    write_ticks(8'd0);
    repeat (2) send_tick();
    wait_idle();
  endtask

  task automatic test_random_traffic();
    write_ticks(8'd1);
    run_phase(0, 0, 250);
    write_ticks(8'd3);
    run_phase(46, 0, 250);
    write_ticks(8'd255);
    run_phase(0, 46, 120);
    write_ticks(8'($urandom_range(1, 8)));
    run_phase(29, 29, 250);
    write_ticks(8'd2);
    run_phase(29, 29, 130);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs <= hold_reqs + 1;
    repeat (60) send_tick();
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_calendar_rollover();
    test_out_of_range();
    test_prescaler();
    test_random_traffic();
    test_backpressure();
    if (fail_cnt == 0 && stamp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
